### hdl/bdhr_pkg.sv
package bdhr_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_MS        = 3'd0,
    REG_HOLD_SINGLE_MS     = 3'd1,
    REG_HOLD_REPEAT_MS     = 3'd2,
    REG_REPEAT_MS          = 3'd3,
    REG_HOLD_SINGLE_ENABLE = 3'd4,
    REG_HOLD_REPEAT_ENABLE = 3'd5
  } cfg_reg_e;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned InDataW  = 40;  // level + now_ms, padded to bytes
  localparam int unsigned OutDataW = 8;   // four event flags, padded

  // Reset values of the configuration registers
  localparam logic [PeriodW-1:0] DebounceRst    = 16'd50;
  localparam logic [PeriodW-1:0] HoldSingleRst  = 16'd1000;
  localparam logic [PeriodW-1:0] HoldRepeatRst  = 16'd1000;
  localparam logic [PeriodW-1:0] RepeatRst      = 16'd200;

  typedef struct packed {
    logic repeat_ev;
    logic hold_ev;
    logic release_ev;
    logic press_ev;
  } events_t;

endpackage

### hdl/button_debounce_hold_repeat_unit.sv
// Button debounce with long-press hold event and auto-repeat.
//
// Input stream (s_axis_*): one item per button sample, carrying the sampled
// level and the current millisecond time. Output stream (m_axis_*): exactly
// one item per input item, carrying four event flags (press, release, hold,
// repeat). Elapsed time is now_ms minus the stored stamp, 32-bit wrapping.
//
// The events of a sample are computed in the cycle it is accepted and appear
// in the output register on the next edge. Throughput is one item per cycle
// while the receiver takes results, set by the single state update per
// sample; the output register and the sample state update together, so a new
// sample is taken while the previous result is being handed over.
//
// When the receiver stalls, the pending result holds in the output register
// and s_axis_tready drops until it is taken; no debounce state changes meanwhile.
//
// Reset clears the debounce state and loads 50 ms debounce, 1000 ms hold,
// 1000 ms first repeat, 200 ms interval, hold and repeat enabled. A config
// write lands on any edge with cfg_we_i high; indexes past the list are ignored.
module button_debounce_hold_repeat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bdhr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdhr_pkg::PeriodW-1:0]  cfg_wdata_i,
  // sample input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bdhr_pkg::InDataW-1:0]  s_axis_tdata,  // [0] level, [32:1] now_ms, zeros
  // event output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bdhr_pkg::OutDataW-1:0] m_axis_tdata   // [0] press, [1] release,
                                                       // [2] hold, [3] repeat, zeros
);
  import bdhr_pkg::*;

  // configuration
  logic [PeriodW-1:0] debounce_q, hold_single_q, hold_repeat_q, repeat_q;
  logic               hold_single_en_q, hold_repeat_en_q;

  // debounce state
  logic             last_level_q, last_level_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic             press_done_q, press_done_d;
  logic             release_done_q, release_done_d;
  logic             hold_done_q, hold_done_d;

  // result register
  logic    out_valid_q;
  events_t events_q, events_d;

  logic             in_accept;
  logic             level;
  logic [TimeW-1:0] now_ms;
  logic [TimeW-1:0] elapsed;

  assign level         = s_axis_tdata[0];
  assign now_ms        = s_axis_tdata[TimeW:1];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign elapsed       = now_ms - stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q       <= DebounceRst;
      hold_single_q    <= HoldSingleRst;
      hold_repeat_q    <= HoldRepeatRst;
      repeat_q         <= RepeatRst;
      hold_single_en_q <= 1'b1;
      hold_repeat_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE_MS:        debounce_q       <= cfg_wdata_i;
        REG_HOLD_SINGLE_MS:     hold_single_q    <= cfg_wdata_i;
        REG_HOLD_REPEAT_MS:     hold_repeat_q    <= cfg_wdata_i;
        REG_REPEAT_MS:          repeat_q         <= cfg_wdata_i;
        REG_HOLD_SINGLE_ENABLE: hold_single_en_q <= cfg_wdata_i[0];
        REG_HOLD_REPEAT_ENABLE: hold_repeat_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Per-sample event logic. Hold and repeat see the press mark as updated
  // by this same sample, so press, hold and repeat may fire together.
  always_comb begin
    last_level_d   = level;
    stamp_d        = stamp_q;
    press_done_d   = press_done_q;
    release_done_d = release_done_q;
    hold_done_d    = hold_done_q;
    events_d       = '0;
    if (level != last_level_q) begin
      // level change: restart stable time, no events
      stamp_d        = now_ms;
      press_done_d   = 1'b0;
      release_done_d = 1'b0;
      hold_done_d    = 1'b0;
    end else begin
      if (elapsed > {{(TimeW-PeriodW){1'b0}}, debounce_q}) begin
        if (level) begin
          if (!press_done_q) begin
            press_done_d      = 1'b1;
            events_d.press_ev = 1'b1;
          end
        end else begin
          if (!release_done_q) begin
            release_done_d      = 1'b1;
            events_d.release_ev = 1'b1;
          end
        end
      end
      if (hold_single_en_q && press_done_d && !hold_done_q &&
          elapsed > {{(TimeW-PeriodW){1'b0}}, hold_single_q}) begin
        hold_done_d      = 1'b1;
        events_d.hold_ev = 1'b1;
      end
      if (hold_repeat_en_q && press_done_d &&
          elapsed > {{(TimeW-PeriodW){1'b0}}, hold_repeat_q}) begin
        // stamp may move past now when repeat exceeds first-repeat time
        stamp_d = now_ms - {{(TimeW-PeriodW){1'b0}}, hold_repeat_q}
                         + {{(TimeW-PeriodW){1'b0}}, repeat_q};
        events_d.repeat_ev = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q   <= 1'b0;
      stamp_q        <= '0;
      press_done_q   <= 1'b0;
      release_done_q <= 1'b0;
      hold_done_q    <= 1'b0;
    end else if (in_accept) begin
      last_level_q   <= last_level_d;
      stamp_q        <= stamp_d;
      press_done_q   <= press_done_d;
      release_done_q <= release_done_d;
      hold_done_q    <= hold_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      events_q <= events_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-4){1'b0}}, events_q};

  // Assertions
  a_press_xor_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(events_q.press_ev && events_q.release_ev))
    else $error("press and release on one item");

  a_hold_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (events_q.hold_ev || events_q.repeat_ev)) |-> press_done_q)
    else $error("hold or repeat without recognized press");

  a_release_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && events_q.release_ev) |->
      (!events_q.hold_ev && !events_q.repeat_ev))
    else $error("release together with hold or repeat");

  a_change_no_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (level != last_level_q)) |=> (events_q == '0))
    else $error("events on a level change");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule
